/* design/kdt_pkg.sv */
// shared types, constants and the per-key update rule for the key debouncer
package kdt_pkg;

  localparam int NumKeys = 16;
  localparam int KeyW    = $clog2(NumKeys);
  localparam int CntW    = 8;
  localparam int ThrW    = 7;

  localparam logic [ThrW-1:0] PressTimeReset = 7'd10;

  // one entry of the per-key state table
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            held;
    logic            toggle;
  } key_state_t;

  // memory write request from the update stage
  typedef struct packed {
    logic            en;
    logic [KeyW-1:0] addr;
    key_state_t      data;
  } mem_wr_t;

  // one scan tick applied to one key entry
  function automatic key_state_t key_update(key_state_t cur, logic pressed,
                                            logic [ThrW-1:0] thr);
    key_state_t      nxt;
    logic [CntW-1:0] thr_w;
    logic [CntW-1:0] full;
    nxt   = cur;
    thr_w = {1'b0, thr};
    full  = {thr, 1'b0};
    if (pressed) begin
      if (cur.cnt < thr_w) begin
        nxt.cnt = thr_w;
      end else if (cur.cnt < full) begin
        nxt.cnt = cur.cnt + CntW'(1);
      end else if (!cur.held) begin
        nxt.held   = 1'b1;
        nxt.toggle = ~cur.toggle;
      end
    end else begin
      if (cur.cnt > thr_w) begin
        nxt.cnt = thr_w;
      end else if (cur.cnt != '0) begin
        nxt.cnt = cur.cnt - CntW'(1);
      end else begin
        nxt.held = 1'b0;
      end
    end
    return nxt;
  endfunction

endpackage

/* design/kdt_state_mem.sv */
// per-key state memory with registered read and per-entry valid bits
module kdt_state_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [kdt_pkg::KeyW-1:0]  rd_addr_i,
  output kdt_pkg::key_state_t       rd_data_o,
  input  kdt_pkg::mem_wr_t          wr_i
);

  kdt_pkg::key_state_t              mem [kdt_pkg::NumKeys];
  logic [kdt_pkg::NumKeys-1:0]      vld_q;
  kdt_pkg::key_state_t              rd_q;
  logic                             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // entries never written read as the reset state
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

/* design/key_debounce_toggle.sv */
// top level of the multiplexed key debouncer with toggle output
// Multiplexed debouncer for up to 16 active-low keys. Each input transfer is
// one scan tick for one key: tdata[3:0] names the key and tdata[4] is the
// sampled pin (0 = pressed). Each key keeps a tick counter, a held flag and a
// toggle flag in a 16-entry state memory. One result transfer comes out for
// every input transfer, in order, carrying the key, its debounced level and
// its toggle bit after the update. The block takes one item per clock while
// the output is not stalled: the state memory is read in the accept cycle and
// written back when the update stage advances, and a key that repeats on the
// next item is served from the last write-back register. The memory read
// registers at the accept edge, and the update stage writes the state back and
// loads the output register together once the output register is free, which
// raises result valid.
// press_time is written through the cfg channel (always ready), reset value 10;
// write it only while no item is in flight.
module key_debounce_toggle (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,      // press_time
  // key samples in
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [3:0] key_index, [4] pin_level, [7:5] zero
  // debounced results out
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata     // [3:0] key_id, [4] debounced_level,
                                      // [5] toggle_state, [7:6] zero
);

  // threshold register
  logic [kdt_pkg::ThrW-1:0] press_time_q;

  // update stage
  logic                       s1_v_q;
  logic [kdt_pkg::KeyW-1:0]   s1_key_q;
  logic                       s1_pin_q;
  logic                       fwd_q;
  logic                       s1_adv;

  // last write-back, used for back-to-back hits on one key
  logic [kdt_pkg::KeyW-1:0]   wr_key_q;
  kdt_pkg::key_state_t        wr_data_q;

  // output register
  logic                       out_v_q;
  logic [kdt_pkg::KeyW-1:0]   out_key_q;
  logic                       out_lvl_q;
  logic                       out_tgl_q;

  logic                       in_xfer;
  logic [kdt_pkg::KeyW-1:0]   in_key;
  kdt_pkg::key_state_t        mem_rd;
  kdt_pkg::key_state_t        cur;
  kdt_pkg::key_state_t        nxt;
  kdt_pkg::mem_wr_t           mem_wr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_time_q <= kdt_pkg::PressTimeReset;
    end else if (cfg_valid_i) begin
      press_time_q <= cfg_data_i;
    end
  end

  // output register frees up when empty or taken this cycle
  assign s1_adv        = !out_v_q || m_axis_tready;
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_key        = s_axis_tdata[kdt_pkg::KeyW-1:0];

  kdt_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (in_key),
    .rd_data_o (mem_rd),
    .wr_i      (mem_wr)
  );

  // same key written back in the accept cycle: memory read is stale
  always_comb begin
    cur = fwd_q ? wr_data_q : mem_rd;
    nxt = kdt_pkg::key_update(cur, !s1_pin_q, press_time_q);
    mem_wr.en   = s1_v_q && s1_adv;
    mem_wr.addr = s1_key_q;
    mem_wr.data = nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      fwd_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_v_q <= 1'b1;
        fwd_q  <= mem_wr.en && (mem_wr.addr == in_key);
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_key_q <= in_key;
      s1_pin_q <= s_axis_tdata[kdt_pkg::KeyW];
    end
    if (mem_wr.en) begin
      wr_key_q  <= s1_key_q;
      wr_data_q <= nxt;
      out_key_q <= s1_key_q;
      out_lvl_q <= nxt.held;
      out_tgl_q <= nxt.toggle;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_tgl_q, out_lvl_q, out_key_q};

`ifndef NO_ASSERTIONS
  // an accepted sample always occupies the update stage next cycle
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_v_q)
    else $error("accepted sample missing from update stage");

  // forwarded data must belong to the key being updated
  a_fwd_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && fwd_q) |-> (wr_key_q == s1_key_q))
    else $error("forwarded entry belongs to a different key");

  // toggle flips only when the held flag rises
  a_toggle_on_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && (nxt.toggle != cur.toggle)) |-> (nxt.held && !cur.held))
    else $error("toggle changed without a debounced press");
`endif

endmodule
